>>> rtl/m7fm_pkg.sv
package m7fm_pkg;

  // Defaults for the top-level parameters.
  localparam int TexWidthLog2Def  = 8;
  localparam int TexHeightLog2Def = 8;
  localparam int ScreenColBitsDef = 10;

  // Configuration port.
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CENTER_X     = 3'd0,
    CFG_CENTER_Y     = 3'd1,
    CFG_HEIGHT_SCALE = 3'd2,
    CFG_HORIZON      = 3'd3,
    CFG_SAMPLE_STEP  = 3'd4,
    CFG_VIEW_ANGLE   = 3'd5,
    CFG_FOV_HALF     = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    ACT_WRITE  = 1'b0,
    ACT_RENDER = 1'b1
  } action_e;

  // Fixed-point widths.
  localparam int DistW      = 24;
  localparam int DividendW  = 28;
  localparam int DivisorW   = 17;
  localparam int TrigW      = 16;
  localparam int AngleW     = 12;
  localparam int FovW       = 11;
  localparam int CordicSteps = 14;
  localparam int CordicStepW = 4;
  localparam int CordicXW    = 24;
  localparam int CordicTW    = 18;
  localparam int CordicX0    = 636751;

  localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};

  typedef struct packed {
    action_e     action;
    logic [7:0]  tex_u;
    logic [7:0]  tex_v;
    logic [31:0] texel;
    logic [9:0]  row;
    logic [9:0]  col;
    logic        sat;
  } item_t;

  typedef struct packed {
    logic signed [TrigW-1:0] sin_a;
    logic signed [TrigW-1:0] cos_a;
    logic signed [TrigW-1:0] sin_b;
    logic signed [TrigW-1:0] cos_b;
  } trig_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_LOAD,
    CS_RUN
  } cordic_state_e;

  // Arctangent of 2^-i in 1/65536-turn units.
  function automatic logic signed [CordicTW-1:0] cordic_atan(input logic [CordicStepW-1:0] i);
    logic signed [CordicTW-1:0] r;
    case (i)
      4'd0:    r = 18'sd8192;
      4'd1:    r = 18'sd4836;
      4'd2:    r = 18'sd2555;
      4'd3:    r = 18'sd1297;
      4'd4:    r = 18'sd651;
      4'd5:    r = 18'sd326;
      4'd6:    r = 18'sd163;
      4'd7:    r = 18'sd81;
      4'd8:    r = 18'sd41;
      4'd9:    r = 18'sd20;
      4'd10:   r = 18'sd10;
      4'd11:   r = 18'sd5;
      4'd12:   r = 18'sd3;
      4'd13:   r = 18'sd1;
      default: r = 18'sd0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/m7fm_in_if.sv
interface m7fm_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [7:0]  tex_u;
  logic [7:0]  tex_v;
  logic [31:0] texel;
  logic [9:0]  row;
  logic [9:0]  col;

  modport source (output valid, action, tex_u, tex_v, texel, row, col, input ready);
  modport sink   (input valid, action, tex_u, tex_v, texel, row, col, output ready);
endinterface

>>> rtl/m7fm_out_if.sv
interface m7fm_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  out_row;
  logic [9:0]  out_col;
  logic [31:0] color;
  logic        dist_saturated;

  modport source (output valid, out_row, out_col, color, dist_saturated, input ready);
  modport sink   (input valid, out_row, out_col, color, dist_saturated, output ready);
endinterface

>>> rtl/mode7_floor_texture_mapper_top.sv
// Mode-7 perspective floor mapper.
// Input channel in_i carries one item per transfer: a texel write (action 0,
// tex_u, tex_v, texel) or a render request (action 1, row, col). Output
// channel out_o carries one pixel per render: row, column, sampled color and
// a flag for a non-positive row distance denominator. Texel writes give no output.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i; the user
// must do so while the block is idle (the block does not enforce it); unknown indexes are ignored.
// Throughput is one item per clock while out_o is not stalled and no direction
// update is running. A render passes 28 bit-per-stage distance divider stages,
// four multiply/add stages, and the texture memory read whose data register is
// the output register. Writes and reads meet the memory in the same stage, so
// every render sees exactly the writes that preceded it.
// After reset, and after each write to the view angle or the field of view,
// the shared CORDIC unit recomputes both edge directions, and in_i.ready stays
// low meanwhile. The texture store has no reset.
// When the receiver stalls, the whole pipeline holds and in_i.ready drops.
module mode7_floor_texture_mapper_top #(
  parameter int TEX_WIDTH_LOG2  = m7fm_pkg::TexWidthLog2Def,
  parameter int TEX_HEIGHT_LOG2 = m7fm_pkg::TexHeightLog2Def,
  parameter int SCREEN_COL_BITS = m7fm_pkg::ScreenColBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  m7fm_in_if.sink                       in_i,
  m7fm_out_if.source                    out_o,
  input  logic                          cfg_we_i,
  input  logic [m7fm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [m7fm_pkg::CfgDataW-1:0] cfg_data_i
);
  import m7fm_pkg::*;

  localparam int AddrW  = TEX_WIDTH_LOG2 + TEX_HEIGHT_LOG2;
  localparam int FracW  = SCREEN_COL_BITS + 16;
  localparam int ProdW  = TrigW + DistW + 1;
  localparam int EdgeW  = 27;
  localparam int DiffW  = EdgeW + 1;
  localparam int PdW    = DiffW + FracW + 1;

  // Configuration registers.
  logic signed [23:0] center_x_q, center_y_q;
  logic [23:0]        height_scale_q;
  logic signed [15:0] horizon_q;
  logic [15:0]        sample_step_q;
  logic [AngleW-1:0]  view_angle_q;
  logic [FovW-1:0]    fov_half_q;
  logic               trig_start;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q     <= '0;
      center_y_q     <= '0;
      height_scale_q <= '0;
      horizon_q      <= 16'sd16;
      sample_step_q  <= 16'd256;
      view_angle_q   <= '0;
      fov_half_q     <= 11'd512;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CENTER_X:     center_x_q     <= cfg_data_i;
        CFG_CENTER_Y:     center_y_q     <= cfg_data_i;
        CFG_HEIGHT_SCALE: height_scale_q <= cfg_data_i;
        CFG_HORIZON:      horizon_q      <= cfg_data_i[15:0];
        CFG_SAMPLE_STEP:  sample_step_q  <= cfg_data_i[15:0];
        CFG_VIEW_ANGLE:   view_angle_q   <= cfg_data_i[AngleW-1:0];
        CFG_FOV_HALF:     fov_half_q     <= cfg_data_i[FovW-1:0];
        default: ;
      endcase
    end
  end

  assign trig_start = cfg_we_i && ((cfg_idx_e'(cfg_idx_i) == CFG_VIEW_ANGLE) ||
                                   (cfg_idx_e'(cfg_idx_i) == CFG_FOV_HALF));

  // Edge directions are a function of configuration only.
  logic  trig_busy;
  trig_t trig;

  m7fm_cordic u_cordic (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (trig_start),
    .view_angle_i (view_angle_q),
    .fov_half_i   (fov_half_q),
    .busy_o       (trig_busy),
    .trig_o       (trig)
  );

  // The whole pipeline moves together; it holds while a result waits.
  logic en, accept, out_vld_q;
  assign en     = !out_vld_q || out_o.ready;
  assign in_i.ready = en && !trig_busy;
  assign accept = in_i.valid && in_i.ready;

  // Row distance denominator in Q.4; not positive means a saturated distance.
  logic signed [17:0] den;
  item_t              in_item;
  assign den = $signed({4'b0000, in_i.row, 4'b0000}) + 18'(horizon_q);

  always_comb begin
    in_item.action = action_e'(in_i.action);
    in_item.tex_u  = in_i.tex_u;
    in_item.tex_v  = in_i.tex_v;
    in_item.texel  = in_i.texel;
    in_item.row    = in_i.row;
    in_item.col    = in_i.col;
    in_item.sat    = den[17] || (den == '0);
  end

  logic                 div_vld;
  item_t                div_item;
  logic [DividendW-1:0] quot;

  m7fm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (accept),
    .item_i     (in_item),
    .dividend_i ({height_scale_q, 4'b0000}),
    .divisor_i  (den[DivisorW-1:0]),
    .valid_o    (div_vld),
    .item_o     (div_item),
    .quot_o     (quot)
  );

  // Stage M: rotate the distance onto both edge directions.
  logic [DistW-1:0]        row_dist;
  logic signed [DistW:0]   dist_s;
  logic                    m_vld_q;
  item_t                   m_item_q;
  logic signed [ProdW-1:0] m_pca_q, m_psa_q, m_pcb_q, m_psb_q;

  assign row_dist = (div_item.sat || (|quot[DividendW-1:DistW])) ? DistMax
                                                                  : quot[DistW-1:0];
  assign dist_s   = $signed({1'b0, row_dist});

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_item_q <= div_item;
      m_pca_q  <= trig.cos_a * dist_s;
      m_psa_q  <= trig.sin_a * dist_s;
      m_pcb_q  <= trig.cos_b * dist_s;
      m_psb_q  <= trig.sin_b * dist_s;
    end
  end

  // Stage P: edge points around the camera centre and the column fraction.
  logic                    p_vld_q;
  item_t                   p_item_q;
  logic signed [EdgeW-1:0] p_sx_q, p_sy_q, p_ex_q, p_ey_q;
  logic [FracW-1:0]        p_frac_q;
  logic [11:0]             col_ext;

  assign col_ext = 12'(m_item_q.col);

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_item_q <= m_item_q;
      p_sx_q   <= EdgeW'(center_x_q) + EdgeW'(m_pca_q >>> 14);
      p_sy_q   <= EdgeW'(center_y_q) - EdgeW'(m_psa_q >>> 14);
      p_ex_q   <= EdgeW'(center_x_q) + EdgeW'(m_pcb_q >>> 14);
      p_ey_q   <= EdgeW'(center_y_q) - EdgeW'(m_psb_q >>> 14);
      p_frac_q <= FracW'(col_ext[SCREEN_COL_BITS-1:0]) * FracW'(sample_step_q);
    end
  end

  // Stage D: span between the edges times the fraction.
  logic                    d_vld_q;
  item_t                   d_item_q;
  logic signed [EdgeW-1:0] d_sx_q, d_sy_q;
  logic signed [PdW-1:0]   d_px_q, d_py_q;
  logic signed [DiffW-1:0] dx, dy;
  logic signed [FracW:0]   frac_s;

  assign dx     = DiffW'(p_ex_q) - DiffW'(p_sx_q);
  assign dy     = DiffW'(p_ey_q) - DiffW'(p_sy_q);
  assign frac_s = $signed({1'b0, p_frac_q});

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_item_q <= p_item_q;
      d_sx_q   <= p_sx_q;
      d_sy_q   <= p_sy_q;
      d_px_q   <= PdW'(dx) * PdW'(frac_s);
      d_py_q   <= PdW'(dy) * PdW'(frac_s);
    end
  end

  // Stage S: sample point and texture address; writes use their own address.
  logic                  s_vld_q;
  item_t                 s_item_q;
  logic [AddrW-1:0]      s_addr_q;
  logic signed [PdW-1:0] px, py;
  logic [11:0]           tu_ext, tv_ext;
  logic [AddrW-1:0]      rd_addr, wr_addr;

  assign px      = PdW'(d_sx_q) + (d_px_q >>> 16);
  assign py      = PdW'(d_sy_q) + (d_py_q >>> 16);
  assign tu_ext  = 12'(d_item_q.tex_u);
  assign tv_ext  = 12'(d_item_q.tex_v);
  assign rd_addr = {py[8 +: TEX_HEIGHT_LOG2], px[8 +: TEX_WIDTH_LOG2]};
  assign wr_addr = {tv_ext[TEX_HEIGHT_LOG2-1:0], tu_ext[TEX_WIDTH_LOG2-1:0]};

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_item_q <= d_item_q;
      s_addr_q <= (d_item_q.action == ACT_RENDER) ? rd_addr : wr_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
      p_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      s_vld_q <= 1'b0;
    end else if (en) begin
      m_vld_q <= div_vld;
      p_vld_q <= m_vld_q;
      d_vld_q <= p_vld_q;
      s_vld_q <= d_vld_q;
    end
  end

  // Texture memory; its read register doubles as the output color register.
  logic [31:0] rdata;

  m7fm_tex_ram #(
    .AddrW (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (en),
    .we_i    (s_vld_q && (s_item_q.action == ACT_WRITE)),
    .addr_i  (s_addr_q),
    .wdata_i (s_item_q.texel),
    .rdata_o (rdata)
  );

  logic [9:0] o_row_q, o_col_q;
  logic       o_sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= s_vld_q && (s_item_q.action == ACT_RENDER);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      o_row_q <= s_item_q.row;
      o_col_q <= s_item_q.col;
      o_sat_q <= s_item_q.sat;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.out_row        = o_row_q;
  assign out_o.out_col        = o_col_q;
  assign out_o.color          = rdata;
  assign out_o.dist_saturated = o_sat_q;

endmodule

>>> rtl/m7fm_cordic.sv
module m7fm_cordic (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [m7fm_pkg::AngleW-1:0]   view_angle_i,
  input  logic [m7fm_pkg::FovW-1:0]     fov_half_i,
  output logic                          busy_o,
  output m7fm_pkg::trig_t               trig_o
);
  import m7fm_pkg::*;

  cordic_state_e state_q, state_d;
  logic                        sel_q;
  logic [CordicStepW-1:0]      step_q;
  logic signed [CordicXW-1:0]  x_q, y_q, nx, ny, xs, ys;
  logic signed [CordicTW-1:0]  t_q, nt, t0, tf;
  logic                        neg_q, negf;
  logic [AngleW-1:0]           ang;
  logic signed [CordicXW-1:0]  cr, sr;
  logic signed [TrigW-1:0]     cq, sq;
  trig_t                       trig_q;

  // Saturating round from Q1.20 to Q1.14.
  function automatic logic signed [TrigW-1:0] to_q14(input logic signed [CordicXW-1:0] v);
    logic signed [CordicXW-1:0] r;
    r = (v + CordicXW'(32)) >>> 6;
    if (r > CordicXW'(16384)) r = CordicXW'(16384);
    if (r < -CordicXW'(16384)) r = -CordicXW'(16384);
    return TrigW'(r);
  endfunction

  always_comb begin
    state_d = state_q;
    case (state_q)
      CS_IDLE: if (start_i) state_d = CS_LOAD;
      CS_LOAD: state_d = start_i ? CS_LOAD : CS_RUN;
      CS_RUN: begin
        if (start_i) begin
          state_d = CS_LOAD;
        end else if (step_q == CordicStepW'(CordicSteps - 1)) begin
          state_d = sel_q ? CS_IDLE : CS_LOAD;
        end
      end
      default: state_d = CS_IDLE;
    endcase
  end

  always_comb begin
    busy_o = (state_q != CS_IDLE);
    trig_o = trig_q;
  end

  // Angle in 1/65536 turn, folded into a quarter turn either side of zero.
  always_comb begin
    ang = sel_q ? (AngleW'(0) - view_angle_i - AngleW'(fov_half_i))
                : (AngleW'(fov_half_i) - view_angle_i);
    t0  = CordicTW'($signed({ang, 4'b0000}));
    tf   = t0;
    negf = 1'b0;
    if (t0 > CordicTW'(16384)) begin
      tf   = t0 - CordicTW'(32768);
      negf = 1'b1;
    end else if (t0 < -CordicTW'(16384)) begin
      tf   = t0 + CordicTW'(32768);
      negf = 1'b1;
    end
  end

  always_comb begin
    xs = x_q >>> step_q;
    ys = y_q >>> step_q;
    if (!t_q[CordicTW-1]) begin
      nx = x_q - ys;
      ny = y_q + xs;
      nt = t_q - cordic_atan(step_q);
    end else begin
      nx = x_q + ys;
      ny = y_q - xs;
      nt = t_q + cordic_atan(step_q);
    end
    cr = nx;
    sr = ny;
    cq = neg_q ? -to_q14(cr) : to_q14(cr);
    sq = neg_q ? -to_q14(sr) : to_q14(sr);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_LOAD;
      sel_q   <= 1'b0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (start_i) begin
        sel_q <= 1'b0;
      end else if (state_q == CS_RUN && step_q == CordicStepW'(CordicSteps - 1)) begin
        sel_q <= ~sel_q;
      end
      if (state_q == CS_RUN) step_q <= step_q + 1'b1;
      else step_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == CS_LOAD) begin
      x_q   <= CordicXW'(CordicX0);
      y_q   <= '0;
      t_q   <= tf;
      neg_q <= negf;
    end else if (state_q == CS_RUN) begin
      x_q <= nx;
      y_q <= ny;
      t_q <= nt;
      if (step_q == CordicStepW'(CordicSteps - 1)) begin
        if (sel_q) begin
          trig_q.cos_b <= cq;
          trig_q.sin_b <= sq;
        end else begin
          trig_q.cos_a <= cq;
          trig_q.sin_a <= sq;
        end
      end
    end
  end

endmodule

>>> rtl/m7fm_div.sv
module m7fm_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  m7fm_pkg::item_t                  item_i,
  input  logic [m7fm_pkg::DividendW-1:0]   dividend_i,
  input  logic [m7fm_pkg::DivisorW-1:0]    divisor_i,
  output logic                             valid_o,
  output m7fm_pkg::item_t                  item_o,
  output logic [m7fm_pkg::DividendW-1:0]   quot_o
);
  import m7fm_pkg::*;

  localparam int Stages = DividendW;

  logic                 vld_q  [Stages];
  item_t                item_q [Stages];
  logic [DivisorW-1:0]  rem_q  [Stages];
  logic [DivisorW-1:0]  dvs_q  [Stages];
  logic [DividendW-1:0] quo_q  [Stages];

  // One quotient bit per stage, restoring form; each stage takes its bit straight from the
  // dividend, which the user must keep static while items are in flight (the block does not enforce it).
  for (genvar k = 0; k < Stages; k++) begin : g_stage
    logic                 vld_in;
    item_t                item_in;
    logic [DivisorW-1:0]  rem_in, dvs_in;
    logic [DividendW-1:0] quo_in;
    logic [DivisorW:0]    trial;
    logic                 ge;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign item_in = item_i;
      assign rem_in  = '0;
      assign dvs_in  = divisor_i;
      assign quo_in  = '0;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign item_in = item_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign dvs_in  = dvs_q[k-1];
      assign quo_in  = quo_q[k-1];
    end

    assign trial = {rem_in, dividend_i[DividendW-1-k]};
    assign ge    = (trial >= {1'b0, dvs_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        item_q[k] <= item_in;
        dvs_q[k]  <= dvs_in;
        rem_q[k]  <= ge ? DivisorW'(trial - {1'b0, dvs_in}) : DivisorW'(trial);
        quo_q[k]  <= {quo_in[DividendW-2:0], ge};
      end
    end
  end

  assign valid_o = vld_q[Stages-1];
  assign item_o  = item_q[Stages-1];
  assign quot_o  = quo_q[Stages-1];

endmodule

>>> rtl/m7fm_tex_ram.sv
module m7fm_tex_ram #(
  parameter int AddrW = 16
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [31:0]      wdata_i,
  output logic [31:0]      rdata_o
);
  logic [31:0] mem [2**AddrW];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) mem[addr_i] <= wdata_i;
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/m7fm_chk.sv
module m7fm_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [9:0]                    out_row_i,
  input logic [31:0]                   out_color_i,
  input logic                          cfg_we_i,
  input logic [m7fm_pkg::CfgIdxW-1:0]  cfg_idx_i
);
  import m7fm_pkg::*;

  // A stalled result stays and keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_row_i) && $stable(out_color_i))
    else $error("stalled output changed");

  // A stalled output freezes the pipeline, so no input may be taken.
  a_stall_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input ready while output stalled");

  // A new view angle or field of view starts a direction update.
  a_trig_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_idx_i == CFG_VIEW_ANGLE || cfg_idx_i == CFG_FOV_HALF) |=> !in_ready_i)
    else $error("input ready during direction update");

endmodule

bind mode7_floor_texture_mapper_top m7fm_chk u_m7fm_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_row_i   (out_o.out_row),
  .out_color_i (out_o.color),
  .cfg_we_i    (cfg_we_i),
  .cfg_idx_i   (cfg_idx_i)
);
